FILE: src/packet_rule_filter_rate_limit_core_macros.svh
// Assertion helpers for the packet filter core
`ifndef PACKET_RULE_FILTER_RATE_LIMIT_CORE_MACROS_SVH
`define PACKET_RULE_FILTER_RATE_LIMIT_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define PRF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define PRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/prf_pkg.sv
package prf_pkg;

  localparam logic [31:0] WindowReset = 32'd1000000000;

  // Interface code that never matches a rule
  localparam logic [1:0] IfaceUnknown = 2'd3;

  typedef enum logic [0:0] {
    FuncRuleWrite = 1'b0,
    FuncClassify  = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [3:0]  rule_index;
    logic [5:0]  flags;
    logic [1:0]  iface;
    logic [7:0]  protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [63:0] rule_limits;
    logic [15:0] packet_length;
    logic [63:0] now_ns;
  } req_t;

  typedef struct packed {
    logic       verdict;
    logic       rule_hit;
    logic [3:0] hit_index;
    logic       rate_untracked;
  } rsp_t;

  // Rate table entry payload: counters and window start
  typedef struct packed {
    logic [63:0] pkts;
    logic [63:0] bytes;
    logic [63:0] wstart;
  } rate_cnt_t;

  // Rule lookup outcome handed from the rule unit to the core
  typedef struct packed {
    logic        hit;
    logic [5:0]  index;
    logic        drop;
    logic [63:0] limits;
  } rule_res_t;

endpackage

FILE: src/packet_rule_filter_rate_limit_core.sv
// Channel  | Signals                          | Notes
// request  | start, busy, req_i               | taken when start & !busy
// result   | done_o, rsp_o                    | one-cycle strobe, no stall
// config   | cfg_we_i, cfg_wdata_i            | window length, written at once
//
// A rule write leaves busy low; its result strobes in the next cycle.
// A packet holds busy for the rule lookup alone when no rate limit applies.
// With a limit: lookup, a key scan over all RateEntries entries (one read a cycle),
// then StRead and StDone to insert or flag a full table, or StRead, StUpd, StDone
// for the counter read-modify-write. done_o rises in the cycle that busy drops.
// After reset a clearing pass over every entry invalidates the key memory;
// busy is high throughout. Results cannot be stalled.
module packet_rule_filter_rate_limit_core import prf_pkg::*; #(
  parameter int unsigned RuleSlots   = 16,
  parameter int unsigned RateEntries = 64,
  localparam int unsigned EntW = (RateEntries > 1) ? $clog2(RateEntries) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  `include "packet_rule_filter_rate_limit_core_macros.svh"

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StRule  = 7'b0000100,
    StScan  = 7'b0001000,
    StRead  = 7'b0010000,
    StUpd   = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e      state_q, state_d;
  req_t        req_q;
  logic [31:0] win_q;
  rule_res_t   rule_res;
  logic        accept;
  logic [EntW:0] ptr_q, ptr_d;
  logic [EntW:0] rd_ptr_q;
  logic [EntW:0] free_q, free_d;
  logic [EntW:0] hitent_q, hitent_d;
  logic        found_q, found_d;
  rsp_t        rsp_d, rsp_q;
  logic        done_d, done_q;

  // Key memory and counter memory
  logic [34:0] key_mem [RateEntries];
  rate_cnt_t   cnt_mem [RateEntries];
  logic [34:0] key_rd_q;
  rate_cnt_t   cnt_rd_q;
  logic        key_we, cnt_we;
  logic [EntW-1:0] key_wa, cnt_addr;
  logic [34:0] key_wd;
  rate_cnt_t   cnt_wd;
  logic [34:0] key_cmp;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  prf_rule_table #(.RuleSlots(RuleSlots)) u_rules (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .wr_i  (accept && (req_i.func == FuncRuleWrite)),
    .req_i (accept ? req_i : req_q),
    .res_o (rule_res)
  );

  // Window length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WindowReset;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign key_cmp = {1'b1, req_q.iface, req_q.src_ip};

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_rd_q <= key_mem[ptr_q[EntW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_addr];
  end

  // Counter update path
  logic [63:0] elapsed, pk_new, by_new;
  logic        restart, over;
  always_comb begin
    elapsed = req_q.now_ns - cnt_rd_q.wstart;
    restart = elapsed > {32'd0, win_q};
    pk_new  = restart ? 64'd1 : cnt_rd_q.pkts + 64'd1;
    by_new  = restart ? {48'd0, req_q.packet_length}
                      : cnt_rd_q.bytes + {48'd0, req_q.packet_length};
    over = (rule_res.limits[63:32] != 32'd0 && pk_new > {32'd0, rule_res.limits[63:32]})
        || (rule_res.limits[31:0] != 32'd0 && by_new > {32'd0, rule_res.limits[31:0]});
  end

  // Control
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    free_d   = free_q;
    hitent_d = hitent_q;
    found_d  = found_q;
    rsp_d    = rsp_q;
    done_d   = 1'b0;
    key_we   = 1'b0;
    key_wa   = ptr_q[EntW-1:0];
    key_wd   = '0;
    cnt_we   = 1'b0;
    cnt_addr = hitent_q[EntW-1:0];
    cnt_wd   = '0;
    case (state_q)
      StClear: begin
        key_we = 1'b1;
        ptr_d  = ptr_q + 1'b1;
        if (ptr_q == (EntW+1)'(RateEntries - 1)) begin
          state_d = StIdle;
          ptr_d   = '0;
        end
      end
      StIdle: begin
        if (accept) begin
          if (req_i.func == FuncRuleWrite) begin
            rsp_d  = '0;
            done_d = 1'b1;
          end else begin
            state_d = StRule;
          end
        end
      end
      StRule: begin
        rsp_d = '0;
        rsp_d.rule_hit  = rule_res.hit;
        rsp_d.hit_index = rule_res.index[3:0];
        if (rule_res.hit && rule_res.limits != 64'd0) begin
          state_d  = StScan;
          ptr_d    = (EntW+1)'(1);
          free_d   = (EntW+1)'(RateEntries);
          found_d  = 1'b0;
        end else begin
          rsp_d.verdict = rule_res.hit && rule_res.drop;
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      StScan: begin
        // key_rd_q holds entry rd_ptr_q
        if (!found_q) begin
          if (key_rd_q == key_cmp) begin
            found_d  = 1'b1;
            hitent_d = rd_ptr_q;
          end else if (!key_rd_q[34] && free_q == (EntW+1)'(RateEntries)) begin
            free_d = rd_ptr_q;
          end
        end
        ptr_d = ptr_q + 1'b1;
        if (rd_ptr_q == (EntW+1)'(RateEntries - 1)) begin
          state_d = StRead;
          ptr_d   = '0;
        end
      end
      StRead: begin
        if (found_q) begin
          cnt_addr = hitent_q[EntW-1:0];
          state_d  = StUpd;
        end else if (free_q != (EntW+1)'(RateEntries)) begin
          key_we   = 1'b1;
          key_wa   = free_q[EntW-1:0];
          key_wd   = key_cmp;
          cnt_we   = 1'b1;
          cnt_addr = free_q[EntW-1:0];
          cnt_wd   = {64'd1, 48'd0, req_q.packet_length, req_q.now_ns};
          state_d  = StDone;
        end else begin
          rsp_d.rate_untracked = 1'b1;
          state_d = StDone;
        end
      end
      StUpd: begin
        cnt_we   = 1'b1;
        cnt_wd   = {pk_new, by_new, restart ? req_q.now_ns : cnt_rd_q.wstart};
        rsp_d.verdict = over;
        state_d  = StDone;
      end
      StDone: begin
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClear;
      ptr_q    <= '0;
      rd_ptr_q <= '0;
      free_q   <= '0;
      hitent_q <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      rd_ptr_q <= ptr_q;
      free_q   <= free_d;
      hitent_q <= hitent_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  `PRF_ASSERT_IMPL(a_done_idle, done_q, !rsp_q.rate_untracked || rsp_q.rule_hit,
                   "untracked without a rule hit")
  `PRF_ASSERT_IMPL(a_no_accept_busy, state_q != StIdle, !accept,
                   "request taken while busy")
  `PRF_ASSERT_NEXT(a_write_done, accept && req_i.func == FuncRuleWrite, done_q,
                   "rule write gave no result")
  `PRF_ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_q), "state not one-hot")

endmodule

FILE: src/prf_rule_table.sv
module prf_rule_table import prf_pkg::*; #(
  parameter int unsigned RuleSlots = 16,
  localparam int unsigned IdxW = (RuleSlots > 1) ? $clog2(RuleSlots) : 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  req_t      req_i,
  output rule_res_t res_o
);

  logic [RuleSlots-1:0] en_q;
  logic [63:0] addr_q  [RuleSlots];
  logic [47:0] match_q [RuleSlots];
  logic [63:0] limit_q [RuleSlots];
  logic [RuleSlots-1:0] hit_vec;
  logic        slot_ok;
  rule_res_t   pick;

  assign slot_ok = ({28'd0, req_i.rule_index} < 32'(RuleSlots));

  // Rule write; enable bits reset so unwritten slots never match
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= '0;
    end else if (wr_i && slot_ok) begin
      en_q[IdxW'(req_i.rule_index)] <= req_i.flags[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i && slot_ok) begin
      addr_q[IdxW'(req_i.rule_index)]  <= {req_i.src_ip, req_i.dst_ip};
      match_q[IdxW'(req_i.rule_index)] <= {req_i.flags, req_i.iface, req_i.protocol,
                                           req_i.sport, req_i.dport};
      limit_q[IdxW'(req_i.rule_index)] <= req_i.rule_limits;
    end
  end

  // Parallel compare of all slots
  always_comb begin
    for (int i = 0; i < RuleSlots; i++) begin
      hit_vec[i] = en_q[i]
        && (match_q[i][41:40] == req_i.iface)
        && (match_q[i][39:32] == 8'd0 || match_q[i][39:32] == req_i.protocol)
        && (!match_q[i][44] || addr_q[i][63:32] == req_i.src_ip)
        && (!match_q[i][45] || addr_q[i][31:0] == req_i.dst_ip)
        && (!match_q[i][46] || (req_i.flags[0] && match_q[i][31:16] == req_i.sport))
        && (!match_q[i][47] || (req_i.flags[0] && match_q[i][15:0] == req_i.dport));
    end
  end

  // Priority pick of the lowest matching slot; unknown interface skips the rules
  always_comb begin
    pick = '0;
    for (int i = RuleSlots - 1; i >= 0; i--) begin
      if (hit_vec[i] && (req_i.iface != IfaceUnknown)) begin
        pick.hit    = 1'b1;
        pick.index  = 6'(i);
        pick.drop   = match_q[i][43];
        pick.limits = limit_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o <= '0;
    end else begin
      res_o <= pick;
    end
  end

endmodule

FILE: tb/sv/packet_rule_filter_rate_limit_core_tb.sv
module packet_rule_filter_rate_limit_core_tb;
  import prf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots    = 16;
  localparam int unsigned NumEntries  = 64;
  localparam int unsigned SettleDelay = NumEntries + 16;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned PoolSize    = 96;

  // Rule flag bits
  localparam int FlgEnable  = 0;
  localparam int FlgDrop    = 1;
  localparam int FlgSrcIp   = 2;
  localparam int FlgDstIp   = 3;
  localparam int FlgSrcPort = 4;
  localparam int FlgDstPort = 5;
  // Packet flag bit
  localparam int FlgHasL4   = 0;
  // Interface codes
  localparam logic [1:0] IfInternal  = 2'd0;
  localparam logic [1:0] IfExternal  = 2'd1;
  localparam logic [1:0] IfGenerator = 2'd2;
  localparam logic [1:0] IfUnknown   = 2'd3;

  typedef struct {
    req_t req;
    bit   fixed;
    rsp_t rsp;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        done;
  rsp_t        rsp_o;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // Request-side hint: a hand-typed verdict for the current directed row
  bit   fixed_valid;
  rsp_t fixed_rsp;

  // Filter state mirror
  logic [31:0] win_len;
  logic [31:0] rule_sip   [NumSlots];
  logic [31:0] rule_dip   [NumSlots];
  logic [5:0]  rule_flags [NumSlots];
  logic [1:0]  rule_iface [NumSlots];
  logic [7:0]  rule_proto [NumSlots];
  logic [15:0] rule_sp    [NumSlots];
  logic [15:0] rule_dp    [NumSlots];
  logic [63:0] rule_lim   [NumSlots];
  bit          ent_valid  [NumEntries];
  logic [1:0]  ent_iface  [NumEntries];
  logic [31:0] ent_ip     [NumEntries];
  logic [63:0] ent_pkts   [NumEntries];
  logic [63:0] ent_bytes  [NumEntries];
  logic [63:0] ent_wstart [NumEntries];

  rsp_t        verdict_q[$];
  int unsigned errors, requests, results, drops, untracked_cnt, hits, idle_cycles;
  logic [31:0] ip_pool[PoolSize];
  logic [63:0] now_base;
  bit          quiet;

  packet_rule_filter_rate_limit_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // First-match classification plus rate accounting; updates the mirror
  function automatic rsp_t classify(req_t r);
    rsp_t        o;
    int          slot, e, free_e;
    bit          l4, ok;
    logic [31:0] lp, lb;
    o = '0;
    if (r.func == FuncRuleWrite) begin
      rule_sip[r.rule_index]   = r.src_ip;
      rule_dip[r.rule_index]   = r.dst_ip;
      rule_flags[r.rule_index] = r.flags;
      rule_iface[r.rule_index] = r.iface;
      rule_proto[r.rule_index] = r.protocol;
      rule_sp[r.rule_index]    = r.sport;
      rule_dp[r.rule_index]    = r.dport;
      rule_lim[r.rule_index]   = r.rule_limits;
      return o;
    end
    if (r.iface == IfUnknown) return o;
    l4 = r.flags[FlgHasL4];
    slot = -1;
    for (int i = 0; i < NumSlots; i++) begin
      ok = rule_flags[i][FlgEnable] && rule_iface[i] == r.iface &&
           (rule_proto[i] == 8'd0 || rule_proto[i] == r.protocol) &&
           (!rule_flags[i][FlgSrcIp] || rule_sip[i] == r.src_ip) &&
           (!rule_flags[i][FlgDstIp] || rule_dip[i] == r.dst_ip) &&
           (!rule_flags[i][FlgSrcPort] || (l4 && rule_sp[i] == r.sport)) &&
           (!rule_flags[i][FlgDstPort] || (l4 && rule_dp[i] == r.dport));
      if (ok && slot < 0) slot = i;
    end
    if (slot < 0) return o;
    o.rule_hit  = 1'b1;
    o.hit_index = slot[3:0];
    lp = rule_lim[slot][63:32];
    lb = rule_lim[slot][31:0];
    if (lp == '0 && lb == '0) begin
      o.verdict = rule_flags[slot][FlgDrop];
      return o;
    end
    // Exact-match lookup, lowest free slot for a new pair
    e = -1;
    free_e = -1;
    for (int k = 0; k < NumEntries; k++) begin
      if (ent_valid[k] && ent_iface[k] == r.iface && ent_ip[k] == r.src_ip && e < 0) e = k;
      if (!ent_valid[k] && free_e < 0) free_e = k;
    end
    if (e >= 0) begin
      if (r.now_ns - ent_wstart[e] > {32'd0, win_len}) begin
        ent_pkts[e]   = 64'd1;
        ent_bytes[e]  = {48'd0, r.packet_length};
        ent_wstart[e] = r.now_ns;
      end else begin
        ent_pkts[e]  = ent_pkts[e] + 64'd1;
        ent_bytes[e] = ent_bytes[e] + {48'd0, r.packet_length};
      end
      o.verdict = (lp != '0 && ent_pkts[e] > {32'd0, lp}) ||
                  (lb != '0 && ent_bytes[e] > {32'd0, lb});
    end else if (free_e >= 0) begin
      ent_valid[free_e]  = 1'b1;
      ent_iface[free_e]  = r.iface;
      ent_ip[free_e]     = r.src_ip;
      ent_pkts[free_e]   = 64'd1;
      ent_bytes[free_e]  = {48'd0, r.packet_length};
      ent_wstart[free_e] = r.now_ns;
    end else begin
      o.rate_untracked = 1'b1;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  function automatic req_t rule_req(logic [3:0] idx, logic [5:0] fl, logic [1:0] ifc,
                                    logic [7:0] pr, logic [31:0] sip, logic [31:0] dip,
                                    logic [15:0] sp, logic [15:0] dp, logic [63:0] lim);
    req_t r;
    r = '0;
    r.func = FuncRuleWrite;
    r.rule_index = idx; r.flags = fl; r.iface = ifc; r.protocol = pr;
    r.src_ip = sip; r.dst_ip = dip; r.sport = sp; r.dport = dp;
    r.rule_limits = lim;
    return r;
  endfunction

  function automatic req_t pkt_req(logic [5:0] fl, logic [1:0] ifc, logic [7:0] pr,
                                   logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
                                   logic [15:0] dp, logic [15:0] len, logic [63:0] now);
    req_t r;
    r = '0;
    r.func = FuncClassify;
    r.flags = fl; r.iface = ifc; r.protocol = pr;
    r.src_ip = sip; r.dst_ip = dip; r.sport = sp; r.dport = dp;
    r.packet_length = len; r.now_ns = now;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(bit v, bit h, logic [3:0] idx, bit u);
    rsp_t o;
    o.verdict = v; o.rule_hit = h; o.hit_index = idx; o.rate_untracked = u;
    return o;
  endfunction

  // Request and result monitor, plus stall watchdog
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (cfg_we) win_len = cfg_wdata;
      if (start && !busy) begin
        want = classify(req_i);
        if (fixed_valid) want = fixed_rsp;
        verdict_q.push_back(want);
        requests++;
        idle_cycles = 0;
      end
      if (done) begin
        idle_cycles = 0;
        results++;
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", rsp_o));
        end else begin
          want = verdict_q.pop_front();
          if (rsp_o.verdict !== want.verdict)
            report_mismatch($sformatf("verdict %b exp %b", rsp_o.verdict, want.verdict));
          if (rsp_o.rule_hit !== want.rule_hit)
            report_mismatch($sformatf("rule_hit %b exp %b", rsp_o.rule_hit, want.rule_hit));
          if (rsp_o.hit_index !== want.hit_index)
            report_mismatch($sformatf("hit_index %0d exp %0d", rsp_o.hit_index,
                                      want.hit_index));
          if (rsp_o.rate_untracked !== want.rate_untracked)
            report_mismatch($sformatf("rate_untracked %b exp %b", rsp_o.rate_untracked,
                                      want.rate_untracked));
          drops += rsp_o.verdict;
          hits += rsp_o.rule_hit;
          untracked_cnt += rsp_o.rate_untracked;
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no progress for %0d cycles", StallLimit);
        $display("packet_rule_filter_rate_limit_core verification failed");
        $finish;
      end
    end
  end

  // Issue one request and wait for it to be taken
  task automatic send_request(req_t r, bit chk, rsp_t e);
    start       <= 1'b1;
    req_i       <= r;
    fixed_valid <= chk;
    fixed_rsp   <= e;
    do @(posedge clk_i); while (busy);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      req_i <= req_t'(($bits(req_t))'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom}));
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    fixed_valid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic write_window(logic [31:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_ip();
    return ($urandom_range(0, 15) == 0) ? $urandom : ip_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  function automatic logic [15:0] pick_port();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(79, 82));
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 3))
      0: return 8'd6;
      1: return 8'd17;
      2: return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random rule: mostly enabled, often rate limited with small limits
  function automatic req_t rand_rule();
    logic [5:0]  fl;
    logic [63:0] lim;
    fl = 6'($urandom);
    if ($urandom_range(0, 7) != 0) fl[FlgEnable] = 1'b1;
    case ($urandom_range(0, 5))
      0, 1: lim = '0;
      2: lim = {32'($urandom_range(1, 4)), 32'd0};
      3: lim = {32'd0, 32'($urandom_range(100, 40000))};
      4: lim = {32'($urandom_range(1, 6)), 32'($urandom_range(1000, 90000))};
      default: lim = {$urandom, $urandom};
    endcase
    return rule_req(4'($urandom), fl, 2'($urandom_range(0, 3) == 3 ? 3 : $urandom_range(0, 2)),
                    pick_proto(), pick_ip(), pick_ip(), pick_port(), pick_port(), lim);
  endfunction

  function automatic req_t rand_packet(logic [31:0] w);
    logic [63:0] now;
    case ($urandom_range(0, 9))
      0: now = {$urandom, $urandom};
      1: now = now_base - 64'($urandom_range(0, 1000));
      default: begin
        now_base = now_base + 64'($urandom_range(0, 3)) * ({32'd0, w} / 3 + 1);
        now = now_base;
      end
    endcase
    return pkt_req(6'($urandom), 2'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2)),
                   pick_proto(), pick_ip(), pick_ip(), pick_port(), pick_port(),
                   ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(40, 1500)),
                   now);
  endfunction

  initial begin
    dir_row_t    rows[$];
    logic [31:0] windows[$];
    rsp_t        zero_rsp;
    clk_i = 1'b0; rst_ni = 1'b0; start = 1'b0; req_i = '0;
    cfg_we = 1'b0; cfg_wdata = '0; fixed_valid = 1'b0; fixed_rsp = '0;
    errors = 0; requests = 0; results = 0; drops = 0; hits = 0;
    untracked_cnt = 0; idle_cycles = 0; quiet = 1'b0;
    win_len = WindowReset;
    for (int i = 0; i < NumSlots; i++) begin
      rule_sip[i] = '0; rule_dip[i] = '0; rule_flags[i] = '0; rule_iface[i] = '0;
      rule_proto[i] = '0; rule_sp[i] = '0; rule_dp[i] = '0; rule_lim[i] = '0;
    end
    for (int k = 0; k < NumEntries; k++) ent_valid[k] = 1'b0;
    for (int k = 0; k < PoolSize; k++) ip_pool[k] = $urandom;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    now_base = 64'd5000;
    zero_rsp = '0;

    // Directed requests
    rows.push_back('{pkt_req(6'h3f, IfInternal, 8'd6, '0, '0, '0, '0, '0, '0), 1'b1,
                     zero_rsp});
    rows.push_back('{pkt_req(6'h01, IfUnknown, 8'hff, '1, '1, '1, '1, '1, '1), 1'b1,
                     zero_rsp});
    rows.push_back('{rule_req(4'd0, 6'b000111, IfInternal, 8'd6, 32'h0a000001, '0, '0, '0, '0),
                     1'b1, zero_rsp});
    rows.push_back('{pkt_req(6'h00, IfInternal, 8'd6, 32'h0a000001, 32'h1, 16'd1, 16'd2,
                             16'd60, 64'd10), 1'b1, mk_rsp(1, 1, 4'd0, 0)});
    rows.push_back('{rule_req(4'd15, 6'h3f, IfUnknown, 8'hff, '1, '1, '1, '1, '1),
                     1'b1, zero_rsp});
    rows.push_back('{pkt_req(6'h3f, IfUnknown, 8'hff, '1, '1, '1, '1, '1, '1), 1'b1,
                     zero_rsp});
    rows.push_back('{rule_req(4'd1, 6'b010001, IfExternal, 8'd0, '0, '0, 16'd80, '0, '0),
                     1'b1, zero_rsp});
    rows.push_back('{pkt_req(6'h00, IfExternal, 8'd17, 32'h5, 32'h6, 16'd80, 16'd9,
                             16'd100, 64'd20), 1'b1, zero_rsp});
    rows.push_back('{pkt_req(6'h01, IfExternal, 8'd17, 32'h5, 32'h6, 16'd80, 16'd9,
                             16'd100, 64'd30), 1'b1, mk_rsp(0, 1, 4'd1, 0)});
    rows.push_back('{rule_req(4'd2, 6'b100011, IfGenerator, 8'd17, '0, '0, '0, 16'd53,
                              {32'd2, 32'd0}), 1'b1, zero_rsp});
    // First packet, within limit, over the limit, then after the window
    rows.push_back('{pkt_req(6'h01, IfGenerator, 8'd17, 32'hc0a80001, '0, '0, 16'd53,
                             16'd64, 64'd100), 1'b0, zero_rsp});
    rows.push_back('{pkt_req(6'h01, IfGenerator, 8'd17, 32'hc0a80001, '0, '0, 16'd53,
                             16'd64, 64'd200), 1'b0, zero_rsp});
    rows.push_back('{pkt_req(6'h01, IfGenerator, 8'd17, 32'hc0a80001, '0, '0, 16'd53,
                             16'd64, 64'd300), 1'b0, zero_rsp});
    rows.push_back('{pkt_req(6'h01, IfGenerator, 8'd17, 32'hc0a80001, '0, '0, 16'd53,
                             16'd64, 64'd2000000000), 1'b0, zero_rsp});
    // Byte limit, and a time earlier than the window start (wraps)
    rows.push_back('{rule_req(4'd3, 6'b000001, IfInternal, 8'd0, '0, '0, '0, '0,
                              {32'd0, 32'd1000}), 1'b1, zero_rsp});
    rows.push_back('{pkt_req(6'h00, IfInternal, 8'd1, 32'h7, '0, '0, '0, 16'hffff,
                             64'd50), 1'b0, zero_rsp});
    rows.push_back('{pkt_req(6'h00, IfInternal, 8'd1, 32'h7, '0, '0, '0, 16'd10,
                             64'd40), 1'b0, zero_rsp});
    rows.push_back('{pkt_req(6'h00, IfInternal, 8'd1, 32'h7, '0, '0, '0, 16'd10,
                             '1), 1'b0, zero_rsp});
    // Disabled rule in a higher-priority slot does not hide a later one
    rows.push_back('{rule_req(4'd0, 6'b111110, IfInternal, 8'd0, '0, '0, '0, '0, '1),
                     1'b1, zero_rsp});
    rows.push_back('{pkt_req(6'h00, IfInternal, 8'd99, 32'h8, '0, '0, '0, 16'd0,
                             64'd60), 1'b0, zero_rsp});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_request(rows[i].req, rows[i].fixed, rows[i].rsp);

    // Random phases, each under its own window length
    windows = '{32'd1000, 32'd0, 32'd1, 32'hffffffff, 32'd50000};
    foreach (windows[p]) begin
      write_window(windows[p]);
      if (p == windows.size() - 1) quiet = 1'b1;
      repeat (PhaseItems) begin
        if ($urandom_range(0, 4) == 0) send_request(rand_rule(), 1'b0, zero_rsp);
        else send_request(rand_packet(windows[p]), 1'b0, zero_rsp);
      end
    end
    drain();

    $display("%0d requests, %0d results: %0d rule hits, %0d drops, %0d untracked",
             requests, results, hits, drops, untracked_cnt);
    $display("window lengths swept from 0 to all ones, rate table driven to full");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("packet_rule_filter_rate_limit_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, verdict_q.size());
      $display("packet_rule_filter_rate_limit_core verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/prf_pkg.sv
src/prf_rule_table.sv
src/packet_rule_filter_rate_limit_core.sv
tb/sv/packet_rule_filter_rate_limit_core_tb.sv
